@@ hdl/modular_recurrence_matrix_power_macros.svh @@
// Assertion macros used by the checker file.
`ifndef MODULAR_RECURRENCE_MATRIX_POWER_MACROS_SVH
`define MODULAR_RECURRENCE_MATRIX_POWER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MRMP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/mrmp_pkg.sv @@
package mrmp_pkg;

   localparam int WORD_BITS_DEFAULT = 62;
   localparam logic [61:0] MODULUS_RESET = 62'd1000000007;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic red_step;
      logic setup;
      logic mul_start;
      logic mul_step;
      logic mul_write;
      logic sq_sel;
      logic shift_n;
      logic out_load;
   } mrmp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic n_zero;
      logic n_lsb;
   } mrmp_stat_type;

   // Modular add of two reduced operands; operands and modulus fit 62 bits.
   function automatic logic [63:0] mod_add64(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] m);
      logic [63:0] s;
      s = a + b;
      if (s >= m) begin
         s = s - m;
      end
      return s;
   endfunction

endpackage

@@ hdl/mrmp_mulmod.sv @@
module mrmp_mulmod
   import mrmp_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 start,
   input  logic                 step,
   input  logic [WORD_BITS-1:0] x_i,
   input  logic [WORD_BITS-1:0] y_i,
   input  logic [WORD_BITS-1:0] m_i,
   output logic [WORD_BITS-1:0] acc_o
);

   logic [WORD_BITS-1:0] acc_ff, x_ff, y_ff;
   logic [WORD_BITS-1:0] acc_in, x_in, y_in;
   logic [WORD_BITS-1:0] acc_add, x_dbl;

   assign acc_add = WORD_BITS'(mod_add64(64'(acc_ff), 64'(x_ff), 64'(m_i)));
   assign x_dbl   = WORD_BITS'(mod_add64(64'(x_ff), 64'(x_ff), 64'(m_i)));

   // Shift-and-add: add x on a set multiplier bit, double x each step.
   always_comb begin
      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      if (start) begin
         acc_in = '0;
         x_in   = x_i;
         y_in   = y_i;
      end else if (step) begin
         if (y_ff[0]) begin
            acc_in = acc_add;
         end
         x_in = x_dbl;
         y_in = y_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign acc_o = acc_ff;

endmodule

@@ hdl/mrmp_datapath.sv @@
module mrmp_datapath
   import mrmp_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [WORD_BITS-1:0] csr_wdata,
   input  logic [WORD_BITS-1:0] steps_i,
   input  logic [WORD_BITS-1:0] base_i,
   input  mrmp_cmd_type         cmd,
   output mrmp_stat_type        stat,
   output logic [WORD_BITS-1:0] count_o
);

   logic [WORD_BITS-1:0] modulus_ff;
   logic [WORD_BITS-1:0] m_ff, n_ff, b_ff, r_ff, count_ff;
   logic [WORD_BITS-1:0] p_ff [4];
   logic [WORD_BITS-1:0] q_ff [4];
   logic [WORD_BITS-1:0] left [4];
   logic [WORD_BITS-1:0] lane_acc [8];
   logic [WORD_BITS-1:0] prod [4];
   logic [WORD_BITS:0]   red_shift;
   logic [WORD_BITS-1:0] red_next, c_val, one_val;

   // Modulus register.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[WORD_BITS-1:0];
      end else if (csr_we) begin
         modulus_ff <= csr_wdata;
      end
   end

   // Restoring reduction of base, one bit per step.
   assign red_shift = {r_ff, b_ff[WORD_BITS-1]};
   assign red_next  = (red_shift >= {1'b0, m_ff}) ? WORD_BITS'(red_shift - {1'b0, m_ff})
                                                   : WORD_BITS'(red_shift);
   assign c_val     = (r_ff == '0) ? m_ff - WORD_BITS'(1) : r_ff - WORD_BITS'(1);
   assign one_val   = (m_ff == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

   // Left operand of the matrix product: B when squaring, else P.
   always_comb begin
      for (int e = 0; e < 4; e++) begin
         left[e] = cmd.sq_sel ? q_ff[e] : p_ff[e];
      end
   end

   // Eight multiply lanes, lane {i,j,t} forms left[i][t] * B[t][j].
   for (genvar k = 0; k < 8; k++) begin : g_lane
      mrmp_mulmod #(.WORD_BITS(WORD_BITS)) u_lane (
         .clock (clock),
         .start (cmd.mul_start),
         .step  (cmd.mul_step),
         .x_i   (left[(k / 4) * 2 + (k % 2)]),
         .y_i   (q_ff[(k % 2) * 2 + ((k / 2) % 2)]),
         .m_i   (m_ff),
         .acc_o (lane_acc[k])
      );
   end

   always_comb begin
      for (int e = 0; e < 4; e++) begin
         prod[e] = WORD_BITS'(mod_add64(64'(lane_acc[2*e]), 64'(lane_acc[2*e+1]),
                                        64'(m_ff)));
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         m_ff  <= (modulus_ff < WORD_BITS'(2)) ? WORD_BITS'(1) : modulus_ff;
         n_ff  <= steps_i;
         b_ff  <= base_i;
         r_ff  <= '0;
      end
      if (cmd.red_step) begin
         r_ff <= red_next;
         b_ff <= b_ff << 1;
      end
      if (cmd.setup) begin
         q_ff[0] <= '0;
         q_ff[1] <= c_val;
         q_ff[2] <= one_val;
         q_ff[3] <= c_val;
         p_ff[0] <= one_val;
         p_ff[1] <= '0;
         p_ff[2] <= '0;
         p_ff[3] <= one_val;
      end
      if (cmd.mul_write) begin
         for (int e = 0; e < 4; e++) begin
            if (cmd.sq_sel) begin
               q_ff[e] <= prod[e];
            end else begin
               p_ff[e] <= prod[e];
            end
         end
      end
      if (cmd.shift_n) begin
         n_ff <= n_ff >> 1;
      end
      if (cmd.out_load) begin
         count_ff <= WORD_BITS'(mod_add64(64'(p_ff[0]), 64'(p_ff[1]), 64'(m_ff)));
      end
   end

   assign stat.n_zero = (n_ff == '0);
   assign stat.n_lsb  = n_ff[0];
   assign count_o     = count_ff;

endmodule

@@ hdl/mrmp_ctrl.sv @@
module mrmp_ctrl
   import mrmp_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  mrmp_stat_type stat,
   output mrmp_cmd_type  cmd
);

   localparam int CW = $clog2(WORD_BITS);

   typedef enum logic [2:0] {
      S_IDLE, S_REDUCE, S_SETUP, S_CHECK, S_START, S_MUL, S_WRITE, S_FINISH
   } state_type;

   state_type      state_ff;
   logic [CW-1:0]  cnt_ff;
   logic           sq_ff;
   logic           rsp_valid_ff;
   logic           last;
   logic           out_free;

   assign last     = (cnt_ff == CW'(WORD_BITS - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Decode commands from the state.
   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == S_IDLE) && req_valid;
      cmd.red_step  = (state_ff == S_REDUCE);
      cmd.setup     = (state_ff == S_SETUP);
      cmd.mul_start = (state_ff == S_START);
      cmd.mul_step  = (state_ff == S_MUL);
      cmd.mul_write = (state_ff == S_WRITE);
      cmd.sq_sel    = sq_ff;
      cmd.shift_n   = (state_ff == S_WRITE) && sq_ff;
      cmd.out_load  = (state_ff == S_FINISH) && out_free;
   end

   // Sequence the reduction, then square-and-multiply over exponent bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sq_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Raise valid on a new result, else drop it after a transfer.
         priority if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_valid) begin
                  state_ff <= S_REDUCE;
               end
            end
            S_REDUCE: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (last) begin
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (stat.n_zero) begin
                  state_ff <= S_FINISH;
               end else begin
                  sq_ff    <= !stat.n_lsb;
                  state_ff <= S_START;
               end
            end
            S_START: begin
               cnt_ff   <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (last) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (sq_ff) begin
                  state_ff <= S_CHECK;
               end else begin
                  sq_ff    <= 1'b1;
                  state_ff <= S_START;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/modular_recurrence_matrix_power.sv @@
// Channel   Ports                     Payload (low bit first)
// request   req_tvalid/tready/tdata   steps, base
// response  rsp_tvalid/tready/tdata   count
// config    csr_we/csr_wdata          modulus
// After a request transfer, the block reduces base (bit-serial remainder) and
// sets up; then each exponent bit takes a squaring, plus a multiply when the
// bit is set (eight shift-add lanes, one multiplier bit a cycle). A zero
// exponent skips the products.
// Reset is synchronous and restores the modulus to 1000000007.
// A stalled response holds; the next request is taken while it waits.
module modular_recurrence_matrix_power
   import mrmp_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [WORD_BITS-1:0]                  csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // steps, base, zero pad
   input  logic [((2*WORD_BITS+7)/8)*8-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // count, zero pad
   output logic [((WORD_BITS+7)/8)*8-1:0]        rsp_tdata
);

   localparam int RSP_W = ((WORD_BITS + 7) / 8) * 8;

   mrmp_cmd_type         cmd;
   mrmp_stat_type        stat;
   logic [WORD_BITS-1:0] count;

   mrmp_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mrmp_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .steps_i   (req_tdata[WORD_BITS-1:0]),
      .base_i    (req_tdata[2*WORD_BITS-1:WORD_BITS]),
      .cmd       (cmd),
      .stat      (stat),
      .count_o   (count)
   );

   assign rsp_tdata = RSP_W'(count);

endmodule

@@ hdl/mrmp_checker.sv @@
`include "modular_recurrence_matrix_power_macros.svh"

module mrmp_checker
   import mrmp_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((WORD_BITS+7)/8)*8-1:0]   rsp_tdata
);

   // Hold a stalled response.
   `MRMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped while stalled")
   `MRMP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "stalled response changed")
   // One item at a time: busy right after a transfer in.
   `MRMP_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")
   // No result rises in the cycle after a request transfer.
   `MRMP_ASSERT_NEXT(a_no_early, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid), "result too early")

endmodule

bind modular_recurrence_matrix_power mrmp_checker #(.WORD_BITS(WORD_BITS)) u_mrmp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ test/modular_recurrence_matrix_power_tb.sv @@
`timescale 1ns / 100ps

module modular_recurrence_matrix_power_tb;
   import mrmp_pkg::*;

   localparam int W = 62;
   localparam int REQ_W = ((2*W+7)/8)*8;
   localparam int RSP_W = ((W+7)/8)*8;
   localparam logic [W-1:0] WORD_MAX = {W{1'b1}};
   localparam int IDLE_LIMIT = 60000;
   localparam int SETTLE_CYCLES = 100;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [W-1:0]     csr_wdata;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // steps, base, zero pad
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // count, zero pad

   logic [W-1:0] expected_counts[$];
   logic [W-1:0] modulus_now;
   int           mismatches;
   int           items_sent;
   int           counts_seen;
   int           moduli_used;
   int           burst_left;
   bit           steady_phase;
   int           quiet_cycles;

   modular_recurrence_matrix_power u_top (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // Modular helpers over 64 bits; operands stay below 2^62
   function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] s;
      s = a + b;
      if (s >= m) s = s - m;
      return s;
   endfunction

   function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] acc;
      acc = 0;
      while (b != 0) begin
         if (b[0]) acc = add_mod(acc, a, m);
         a = add_mod(a, a, m);
         b = b >> 1;
      end
      return acc;
   endfunction

   // Row-0 sum of [[0,c],[1,c]]^steps, all mod the modulus
   function automatic logic [W-1:0] predict_count(logic [W-1:0] steps, logic [W-1:0] base,
                                                  logic [W-1:0] mod_reg);
      logic [63:0] m, b, c, n, r;
      logic [63:0] p00, p01, p10, p11, q00, q01, q10, q11, t00, t01, t10, t11;
      m = mod_reg;
      if (m < 2) m = 1;
      b = base % m;
      c = (b == 0) ? m - 1 : b - 1;
      q00 = 0; q01 = c; q10 = 1 % m; q11 = c;
      p00 = 1 % m; p01 = 0; p10 = 0; p11 = 1 % m;
      n = steps;
      while (n != 0) begin
         if (n[0]) begin
            t00 = add_mod(mul_mod(p00, q00, m), mul_mod(p01, q10, m), m);
            t01 = add_mod(mul_mod(p00, q01, m), mul_mod(p01, q11, m), m);
            t10 = add_mod(mul_mod(p10, q00, m), mul_mod(p11, q10, m), m);
            t11 = add_mod(mul_mod(p10, q01, m), mul_mod(p11, q11, m), m);
            p00 = t00; p01 = t01; p10 = t10; p11 = t11;
         end
         t00 = add_mod(mul_mod(q00, q00, m), mul_mod(q01, q10, m), m);
         t01 = add_mod(mul_mod(q00, q01, m), mul_mod(q01, q11, m), m);
         t10 = add_mod(mul_mod(q10, q00, m), mul_mod(q11, q10, m), m);
         t11 = add_mod(mul_mod(q10, q01, m), mul_mod(q11, q11, m), m);
         q00 = t00; q01 = t01; q10 = t10; q11 = t11;
         n = n >> 1;
      end
      r = add_mod(p00, p01, m);
      return r[W-1:0];
   endfunction

   // Send one request; bursts with random gaps unless in a steady phase
   task automatic send_request(logic [W-1:0] steps, logic [W-1:0] base);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = steady_phase ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-2*W){1'b0}}, base, steps};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_counts.push_back(predict_count(steps, base, modulus_now));
      items_sent++;
   endtask

   // Drop valid and hold until every expected count has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_modulus(logic [W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      modulus_now = value;
      moduli_used++;
   endtask

   task automatic test_reset_modulus();
      send_request('0, '0);
      send_request(1, 1);
      send_request(2, 1000000007);
      send_request(5, WORD_MAX);
      send_request(WORD_MAX, '0);
      send_request(62'h2AAA_AAAA_AAAA_AAAA, 62'h1555_5555_5555_5555);
   endtask

   task automatic test_modulus_extremes();
      write_modulus(2);
      send_request(7, 0);
      send_request(9, 3);
      send_request(WORD_MAX, WORD_MAX);
      write_modulus(WORD_MAX);
      send_request(0, WORD_MAX);
      send_request(3, WORD_MAX - 1);
      send_request(40, 1);
      send_request(62'h1555_5555_5555_5555, 62'h2AAA_AAAA_AAAA_AAAA);
      // moduli below two collapse to one, so every count is zero
      write_modulus(0);
      send_request(0, 5);
      send_request(6, WORD_MAX);
      write_modulus(1);
      send_request(0, 0);
      send_request(11, 77);
      write_modulus(13);
      send_request(4, 13);
      send_request(4, 14);
      send_request(100, 0);
   endtask

   task automatic test_random_items();
      logic [W-1:0] steps, base, m;
      int width;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: m = 1000000007;
            1: m = $urandom_range(2, 50);
            2: m = W'({$urandom, $urandom} & WORD_MAX);
            3: m = WORD_MAX - $urandom_range(0, 3);
            default: m = W'({$urandom, $urandom} >> $urandom_range(2, 60));
         endcase
         write_modulus(m);
         steady_phase = (phase == 2);
         for (int i = 0; i < 16; i++) begin
            // mostly short exponents; a few full-width ones
            width = ($urandom_range(0, 19) == 0) ? W : $urandom_range(0, 12);
            steps = W'(({$urandom, $urandom} & WORD_MAX) >> (W - width));
            if (width == 0) steps = '0;
            base = W'({$urandom, $urandom} & WORD_MAX);
            if ($urandom_range(0, 3) == 0) base = base % m;
            send_request(steps, base);
            if (i == 10) wait_drained();
         end
      end
      steady_phase = 1'b0;
   endtask

   // Receiver stall pattern: long open stretches mixed with choppy ones
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if ((items_sent / 16) % 2 == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 2) != 0);
      end
   end

   // Compare each count transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         counts_seen++;
         if (expected_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected count %0d", rsp_tdata[W-1:0]);
         end else begin
            if (rsp_tdata[W-1:0] !== expected_counts[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: count expected %0d got %0d",
                           expected_counts[0], rsp_tdata[W-1:0]);
            end
            void'(expected_counts.pop_front());
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      mismatches   = 0;
      items_sent   = 0;
      counts_seen  = 0;
      moduli_used  = 1;
      burst_left   = 0;
      steady_phase = 1'b0;
      modulus_now  = MODULUS_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_modulus();
      test_modulus_extremes();
      test_random_items();
      wait_drained();
      if (expected_counts.size() != 0) mismatches++;

      $display("Covered %0d requests, %0d counts, %0d modulus settings incl. 0, 1, 2, max",
               items_sent, counts_seen, moduli_used);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
